// ----- hdl/kalman_constant_velocity_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Kalman filter assertion macros
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef KALMAN_CONSTANT_VELOCITY_FILTER_MACROS_SVH
`define KALMAN_CONSTANT_VELOCITY_FILTER_MACROS_SVH

// property must hold at every clock edge outside reset
`define KCVF_ASSERT_IMPL(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("kcvf property violated");

// condition must never be seen outside reset
`define KCVF_ASSERT_NEVER(lbl, ck, rst_n, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) !(cond)) \
		else $error("kcvf forbidden condition seen");

`endif

// ----- hdl/kcvf_pkg.sv -----
// ----------------------------------------------------------------------------
// Kalman filter package
// Word format, arithmetic unit request/response, configuration and states.
// ----------------------------------------------------------------------------
`default_nettype none

package kcvf_pkg;

	localparam int WORD_W    = 48;
	localparam int FRAC_W    = 16;
	localparam int HALF_W    = WORD_W / 2;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int DIVN_W    = WORD_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIVN_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_U_W   = WORD_W - 1;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam word_t WORD_ONE = {{(WORD_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

	localparam logic [CFG_U_W-1:0] PNOISE_RST = CFG_U_W'(65536);
	localparam logic [CFG_U_W-1:0] MNOISE_RST = CFG_U_W'(65536);
	localparam logic [WORD_W-1:0]  IPOS_RST   = WORD_W'(655360000);
	localparam logic [CFG_U_W-1:0] IVAR_RST   = CFG_U_W'(64'd65536000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE,
		REG_MEASUREMENT_NOISE,
		REG_INITIAL_POSITION,
		REG_INITIAL_VARIANCE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef enum logic [2:0] {
		ALU_IDLE,
		ALU_MUL_RUN,
		ALU_MUL_FIN,
		ALU_DIV_RUN,
		ALU_DIV_FIN
	} alu_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_XP0,
		ST_A00,
		ST_A01,
		ST_SUM,
		ST_P00,
		ST_P10,
		ST_P11,
		ST_Y,
		ST_S,
		ST_K0,
		ST_K1,
		ST_MK0Y,
		ST_X0,
		ST_MK1Y,
		ST_X1,
		ST_M00,
		ST_P0,
		ST_P1,
		ST_T2,
		ST_P2,
		ST_T3,
		ST_P3,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		word_t   a;
		word_t   b;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		logic  clip;
		word_t res;
	} alu_rsp_t;

	typedef struct packed {
		word_t q;
		word_t r;
		word_t init_pos;
		word_t init_var;
	} cfg_t;

	typedef struct packed {
		logic  clip;
		word_t val;
	} sat_t;

	function automatic sat_t sat_ext(input logic [WORD_W:0] v);
		sat_t r;
		r.clip = v[WORD_W] ^ v[WORD_W-1];
		if (r.clip) begin
			r.val = v[WORD_W] ? WORD_MIN : WORD_MAX;
		end else begin
			r.val = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/kcvf_if.sv -----
// ----------------------------------------------------------------------------
// Kalman filter channels
// Valid/ready channels for measurement words and estimate words.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcvf_in_if import kcvf_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t measured_position;

	modport source (output valid, output measured_position, input ready);
	modport sink (input valid, input measured_position, output ready);
endinterface

interface kcvf_out_if import kcvf_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t position_out;
	word_t velocity_out;
	logic  clipped;

	modport source (output valid, output position_out, output velocity_out,
		output clipped, input ready);
	modport sink (input valid, input position_out, input velocity_out,
		input clipped, output ready);
endinterface

`default_nettype wire

// ----- hdl/kcvf_alu.sv -----
// ----------------------------------------------------------------------------
// Kalman filter arithmetic unit
// Shared saturating add/sub, four-step 48x48 multiply, bit-serial divide.
// ----------------------------------------------------------------------------
`default_nettype none

module kcvf_alu import kcvf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam logic [DIVN_W-1:0] QUO_NEG_LIM = DIVN_W'(1) << (WORD_W-1);
	localparam logic [DIVN_W-1:0] QUO_POS_LIM = QUO_NEG_LIM - DIVN_W'(1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVN_W-1);

	alu_state_t state_q, state_d;
	logic done_q, done_d;

	logic                 neg_q;
	logic [WORD_W-1:0]    x_q, y_q;
	logic [PROD_W-1:0]    acc_q;
	logic [DIVN_W-1:0]    num_q, quo_q;
	logic [WORD_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	word_t                res_q;
	logic                 clip_q;

	logic [WORD_W-1:0] mag_a, mag_b;
	logic [WORD_W:0]   sum_w, diff_w;
	sat_t              sum_s, diff_s;
	logic [HALF_W-1:0] xh, yh;
	logic [WORD_W-1:0] pp;
	logic [PROD_W-1:0] pp_sh;
	logic signed [PROD_W:0] prod_s;
	logic              prod_ovf;
	logic [WORD_W:0]   rem_sh, rem_diff;
	logic              ge;

	assign mag_a  = req.a[WORD_W-1] ? WORD_W'(-req.a) : req.a;
	assign mag_b  = req.b[WORD_W-1] ? WORD_W'(-req.b) : req.b;
	assign sum_w  = {req.a[WORD_W-1], req.a} + {req.b[WORD_W-1], req.b};
	assign diff_w = {req.a[WORD_W-1], req.a} - {req.b[WORD_W-1], req.b};
	assign sum_s  = sat_ext(sum_w);
	assign diff_s = sat_ext(diff_w);

	assign xh = cnt_q[1] ? x_q[WORD_W-1:HALF_W] : x_q[HALF_W-1:0];
	assign yh = cnt_q[0] ? y_q[WORD_W-1:HALF_W] : y_q[HALF_W-1:0];
	assign pp = xh * yh;

	always_comb begin
		case (cnt_q[1:0]) inside
			2'b00:        pp_sh = PROD_W'(pp);
			2'b01, 2'b10: pp_sh = PROD_W'(pp) << HALF_W;
			default:      pp_sh = PROD_W'(pp) << WORD_W;
		endcase
	end

	assign prod_s   = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
	assign prod_ovf = !((&prod_s[PROD_W:WORD_W+FRAC_W-1]) ||
		!(|prod_s[PROD_W:WORD_W+FRAC_W-1]));

	assign rem_sh   = {rem_q, num_q[DIVN_W-1]};
	assign rem_diff = rem_sh - {1'b0, y_q};
	assign ge       = ~rem_diff[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ALU_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			ALU_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						ALU_MUL: state_d = ALU_MUL_RUN;
						ALU_DIV: state_d = ALU_DIV_RUN;
						default: done_d = 1'b1;
					endcase
				end
			end
			ALU_MUL_RUN: begin
				if (cnt_q[1:0] == 2'b11) state_d = ALU_MUL_FIN;
			end
			ALU_DIV_RUN: begin
				if (cnt_q == DIV_LAST) state_d = ALU_DIV_FIN;
			end
			ALU_MUL_FIN, ALU_DIV_FIN: begin
				state_d = ALU_IDLE;
				done_d  = 1'b1;
			end
			default: state_d = ALU_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ALU_IDLE: begin
				cnt_q <= '0;
				acc_q <= '0;
				rem_q <= '0;
				neg_q <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
				x_q   <= mag_a;
				y_q   <= mag_b;
				num_q <= {mag_a, {FRAC_W{1'b0}}};
				if (req.start && req.op == ALU_ADD) begin
					res_q  <= sum_s.val;
					clip_q <= sum_s.clip;
				end else if (req.start && req.op == ALU_SUB) begin
					res_q  <= diff_s.val;
					clip_q <= diff_s.clip;
				end
			end
			ALU_MUL_RUN: begin
				acc_q <= acc_q + pp_sh;
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			ALU_MUL_FIN: begin
				clip_q <= prod_ovf;
				if (prod_ovf) begin
					res_q <= prod_s[PROD_W] ? WORD_MIN : WORD_MAX;
				end else begin
					res_q <= prod_s[WORD_W+FRAC_W-1:FRAC_W];
				end
			end
			ALU_DIV_RUN: begin
				rem_q <= ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
				quo_q <= {quo_q[DIVN_W-2:0], ge};
				num_q <= num_q << 1;
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
			ALU_DIV_FIN: begin
				if (neg_q) begin
					clip_q <= quo_q > QUO_NEG_LIM;
					res_q  <= (quo_q > QUO_NEG_LIM) ? WORD_MIN :
						word_t'(~quo_q[WORD_W-1:0] + 1'b1);
				end else begin
					clip_q <= quo_q > QUO_POS_LIM;
					res_q  <= (quo_q > QUO_POS_LIM) ? WORD_MAX : word_t'(quo_q[WORD_W-1:0]);
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.clip = clip_q;
	assign rsp.res  = res_q;

endmodule

`default_nettype wire

// ----- hdl/kcvf_seq.sv -----
// ----------------------------------------------------------------------------
// Kalman filter sequencer
// Steps predict and update through the shared unit and holds filter state.
// ----------------------------------------------------------------------------
`default_nettype none

module kcvf_seq import kcvf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	kcvf_in_if.sink  in_ch,
	kcvf_out_if.source out_ch,
	input  cfg_t     cfg,
	output alu_req_t alu_req,
	input  alu_rsp_t alu_rsp
);

	seq_state_t state_q, state_d, nxt;
	logic issued_q, started_q, out_valid_q;
	logic compute, accept, load_out, s_zero;

	word_t x0_q, x1_q, p0_q, p1_q, p2_q, p3_q, z_q;
	word_t xp0_q, a01_q, p00_q, p10_q, p11_q, y_q, s_q, k0_q, k1_q, m00_q, t_q;
	word_t pos_q, vel_q;
	logic  clip_q, oclip_q;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign load_out    = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);
	assign s_zero      = (s_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (alu_req.start) begin
				issued_q <= 1'b1;
			end else if (alu_rsp.done) begin
				issued_q <= 1'b0;
			end
			if (accept) started_q <= 1'b1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		nxt         = state_q;
		compute     = 1'b1;
		alu_req.op  = ALU_ADD;
		alu_req.a   = '0;
		alu_req.b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				compute = 1'b0;
				if (accept) state_d = ST_XP0;
			end
			ST_XP0: begin alu_req.a = x0_q;  alu_req.b = x1_q;  nxt = ST_A00; end
			ST_A00: begin alu_req.a = p0_q;  alu_req.b = p2_q;  nxt = ST_A01; end
			ST_A01: begin alu_req.a = p1_q;  alu_req.b = p3_q;  nxt = ST_SUM; end
			ST_SUM: begin alu_req.a = t_q;   alu_req.b = a01_q; nxt = ST_P00; end
			ST_P00: begin alu_req.a = t_q;   alu_req.b = cfg.q; nxt = ST_P10; end
			ST_P10: begin alu_req.a = p2_q;  alu_req.b = p3_q;  nxt = ST_P11; end
			ST_P11: begin alu_req.a = p3_q;  alu_req.b = cfg.q; nxt = ST_Y;   end
			ST_Y: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = z_q;
				alu_req.b  = xp0_q;
				nxt        = ST_S;
			end
			ST_S: begin alu_req.a = p00_q; alu_req.b = cfg.r; nxt = ST_K0; end
			ST_K0: begin
				alu_req.op = ALU_DIV;
				alu_req.a  = p00_q;
				alu_req.b  = s_q;
				nxt        = ST_K1;
				if (s_zero) begin
					compute = 1'b0;
					state_d = ST_MK0Y;
				end
			end
			ST_K1: begin
				alu_req.op = ALU_DIV;
				alu_req.a  = p10_q;
				alu_req.b  = s_q;
				nxt        = ST_MK0Y;
			end
			ST_MK0Y: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = k0_q;
				alu_req.b  = y_q;
				nxt        = ST_X0;
			end
			ST_X0: begin alu_req.a = xp0_q; alu_req.b = t_q; nxt = ST_MK1Y; end
			ST_MK1Y: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = k1_q;
				alu_req.b  = y_q;
				nxt        = ST_X1;
			end
			ST_X1: begin alu_req.a = x1_q; alu_req.b = t_q; nxt = ST_M00; end
			ST_M00: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = WORD_ONE;
				alu_req.b  = k0_q;
				nxt        = ST_P0;
			end
			ST_P0: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = m00_q;
				alu_req.b  = p00_q;
				nxt        = ST_P1;
			end
			ST_P1: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = m00_q;
				alu_req.b  = a01_q;
				nxt        = ST_T2;
			end
			ST_T2: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = k1_q;
				alu_req.b  = p00_q;
				nxt        = ST_P2;
			end
			ST_P2: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = p10_q;
				alu_req.b  = t_q;
				nxt        = ST_T3;
			end
			ST_T3: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = k1_q;
				alu_req.b  = a01_q;
				nxt        = ST_P3;
			end
			ST_P3: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = p11_q;
				alu_req.b  = t_q;
				nxt        = ST_OUT;
			end
			ST_OUT: begin
				compute = 1'b0;
				if (load_out) state_d = ST_IDLE;
			end
			default: begin
				compute = 1'b0;
				state_d = ST_IDLE;
			end
		endcase
		alu_req.start = compute && !issued_q;
		if (compute && alu_rsp.done) state_d = nxt;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_q    <= in_ch.measured_position;
			clip_q <= 1'b0;
			if (!started_q) begin
				x0_q <= cfg.init_pos;
				x1_q <= '0;
				p0_q <= cfg.init_var;
				p1_q <= '0;
				p2_q <= '0;
				p3_q <= cfg.init_var;
			end
		end
		if (state_q == ST_K0 && s_zero) begin
			k0_q   <= '0;
			k1_q   <= '0;
			clip_q <= 1'b1;
		end
		if (compute && alu_rsp.done) begin
			clip_q <= clip_q | alu_rsp.clip;
			case (state_q)
				ST_XP0:  xp0_q <= alu_rsp.res;
				ST_A00:  t_q   <= alu_rsp.res;
				ST_A01:  a01_q <= alu_rsp.res;
				ST_SUM:  t_q   <= alu_rsp.res;
				ST_P00:  p00_q <= alu_rsp.res;
				ST_P10:  p10_q <= alu_rsp.res;
				ST_P11:  p11_q <= alu_rsp.res;
				ST_Y:    y_q   <= alu_rsp.res;
				ST_S:    s_q   <= alu_rsp.res;
				ST_K0:   k0_q  <= alu_rsp.res;
				ST_K1:   k1_q  <= alu_rsp.res;
				ST_MK0Y: t_q   <= alu_rsp.res;
				ST_X0:   x0_q  <= alu_rsp.res;
				ST_MK1Y: t_q   <= alu_rsp.res;
				ST_X1:   x1_q  <= alu_rsp.res;
				ST_M00:  m00_q <= alu_rsp.res;
				ST_P0:   p0_q  <= alu_rsp.res;
				ST_P1:   p1_q  <= alu_rsp.res;
				ST_T2:   t_q   <= alu_rsp.res;
				ST_P2:   p2_q  <= alu_rsp.res;
				ST_T3:   t_q   <= alu_rsp.res;
				ST_P3:   p3_q  <= alu_rsp.res;
				default: ;
			endcase
		end
		if (load_out) begin
			pos_q   <= x0_q;
			vel_q   <= x1_q;
			oclip_q <= clip_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.position_out = pos_q;
	assign out_ch.velocity_out = vel_q;
	assign out_ch.clipped      = oclip_q;

endmodule

`default_nettype wire

// ----- hdl/kalman_constant_velocity_filter.sv -----
// ----------------------------------------------------------------------------
// Constant-velocity Kalman filter
// Two-state position/velocity tracker on Q32.16 words with a shared unit.
//
//   channel  dir  payload                                  handshake
//   in_ch    in   measured_position                        valid/ready
//   out_ch   out  position_out, velocity_out, clipped      valid/ready
//   cfg      in   cfg_index, cfg_data                      cfg_we
//
// Each word goes from its accept through 22 steps on one arithmetic unit
// and an output state, which waits while the output register is full.
// The two 64-step bit-serial divisions dominate, ahead of the multiplies
// and the adds and subtracts; both divisions are skipped when s is zero.
// in_ch.ready is high only while the sequencer is idle.
// A finished word waits in the output register; a new input is taken meanwhile.
// Reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_constant_velocity_filter import kcvf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	kcvf_in_if.sink              in_ch,
	kcvf_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic [CFG_U_W-1:0] pnoise_q, mnoise_q, ivar_q;
	logic [WORD_W-1:0]  ipos_q;
	cfg_t               cfg;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnoise_q <= PNOISE_RST;
			mnoise_q <= MNOISE_RST;
			ipos_q   <= IPOS_RST;
			ivar_q   <= IVAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PROCESS_NOISE:     pnoise_q <= cfg_data[CFG_U_W-1:0];
				REG_MEASUREMENT_NOISE: mnoise_q <= cfg_data[CFG_U_W-1:0];
				REG_INITIAL_POSITION:  ipos_q   <= cfg_data;
				REG_INITIAL_VARIANCE:  ivar_q   <= cfg_data[CFG_U_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.q        = {1'b0, pnoise_q};
	assign cfg.r        = {1'b0, mnoise_q};
	assign cfg.init_pos = ipos_q;
	assign cfg.init_var = {1'b0, ivar_q};

	kcvf_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg     (cfg),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	kcvf_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

endmodule

`default_nettype wire

// ----- hdl/kcvf_checker.sv -----
// ----------------------------------------------------------------------------
// Kalman filter port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kalman_constant_velocity_filter_macros.svh"

module kcvf_checker import kcvf_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input word_t position_out,
	input word_t velocity_out,
	input logic  clipped
);

	`KCVF_ASSERT_IMPL(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`KCVF_ASSERT_IMPL(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(position_out) && $stable(velocity_out) && $stable(clipped))
	`KCVF_ASSERT_IMPL(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`KCVF_ASSERT_IMPL(a_no_instant_word, clk, arst_n, in_valid && in_ready |=> !$rose(out_valid))
	`KCVF_ASSERT_NEVER(a_ready_drop_cause, clk, arst_n, $fell(in_ready) && !$past(in_valid && in_ready))

endmodule

bind kalman_constant_velocity_filter kcvf_checker u_kcvf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.position_out (out_ch.position_out),
	.velocity_out (out_ch.velocity_out),
	.clipped      (out_ch.clipped)
);

`default_nettype wire
